// ----- design/kwsl_pkg.sv -----
// Shared types, constants and character helpers for the keyword/string lexer.
`timescale 1ns / 1ps

package kwsl_pkg;

  localparam int MAX_TOKEN_LEN = 64;
  localparam int OFFSET_WIDTH  = 16;
  localparam int START_W       = 16;
  localparam int LEN_W         = 7;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);

  // ASCII codes
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_SQUOTE = 8'd39;

  typedef enum logic [2:0] {
    KIND_FN     = 3'd0,
    KIND_END    = 3'd1,
    KIND_PRINT  = 3'd2,
    KIND_SYMBOL = 3'd3,
    KIND_STRING = 3'd4,
    KIND_COLON  = 3'd5,
    KIND_EOI    = 3'd6,
    KIND_ERROR  = 3'd7
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_STR   = 2'd2
  } lexer_mode_t;

  typedef struct packed {
    token_kind_t            kind;
    logic [START_W-1:0]     start;
    logic [LEN_W-1:0]       length;
    logic                   too_long;
    logic                   last;
  } tok_t;

  // Core to top: tokens produced by this byte, plus halt status
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
    logic       halted;
  } core_out_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'd48 && c <= 8'd57);
  endfunction

  // Keyword lengths: fn, end, print
  function automatic logic [LEN_W-1:0] kw_len(input logic [1:0] idx);
    logic [LEN_W-1:0] r;
    case (idx)
      2'd0:    r = LEN_W'(2);
      2'd1:    r = LEN_W'(3);
      default: r = LEN_W'(5);
    endcase
    return r;
  endfunction

  // Keyword text, one character at a given position
  function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'd0;
    case (idx)
      2'd0: begin
        case (pos)
          3'd0:    r = "f";
          3'd1:    r = "n";
          default: r = 8'd0;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0:    r = "e";
          3'd1:    r = "n";
          3'd2:    r = "d";
          default: r = 8'd0;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    r = "p";
          3'd1:    r = "r";
          3'd2:    r = "i";
          3'd3:    r = "n";
          3'd4:    r = "t";
          default: r = 8'd0;
        endcase
      end
    endcase
    return r;
  endfunction

  // Drop keywords whose next character does not match
  function automatic logic [2:0] kw_match(input logic [2:0] hits, input logic [LEN_W-1:0] pos,
                                          input logic [7:0] c);
    logic [2:0] r;
    r = hits;
    for (int i = 0; i < 3; i++) begin
      if (hits[i]) begin
        if (pos >= kw_len(2'(i)) || kw_char(2'(i), pos[2:0]) != c) begin
          r[i] = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- design/keyword_string_lexer.sv -----
// Top level: streaming lexer for identifiers, keywords, strings and colons.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   byte    | byte_valid, byte_stall, in_byte       | in
//   token   | token_valid, token_stall, token_kind, | out
//           | token_start, token_length, too_long,  |
//           | last                                  |
//
// One byte per cycle while byte_stall is low: a byte is captured in the input
// register, lexed from there and its zero, one or two tokens written to a
// four-entry queue. The lexer proceeds only while the queue has at least two
// free entries. With the result side never stalling the queue holds at most
// two tokens, so the input stalls only after the result side has held off.
// Synchronous reset clears the lexer state and empties the queue.
// After an error the lexer is halted: bytes are still taken but give nothing.
`timescale 1ns / 1ps

module keyword_string_lexer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_stall,
  input  logic [7:0]                   in_byte,
  output logic                         token_valid,
  input  logic                         token_stall,
  output logic [2:0]                   token_kind,
  output logic [kwsl_pkg::START_W-1:0] token_start,
  output logic [kwsl_pkg::LEN_W-1:0]   token_length,
  output logic                         too_long,
  output logic                         last
);
  import kwsl_pkg::*;

  logic [7:0]       src_byte;
  logic             src_valid;
  logic             go;
  logic             room;
  logic             pop;
  core_out_t        core_out;
  tok_t             head;
  logic [CNT_W-1:0] count;

  // Room for a full pair of tokens
  assign room       = count <= CNT_W'(FIFO_DEPTH - 2);
  assign go         = src_valid && room;
  assign byte_stall = src_valid && !room;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      src_valid <= 1'b1;
    end else if (go) begin
      src_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      src_byte <= in_byte;
    end
  end

  kwsl_core u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .cur_byte (src_byte),
    .core_out (core_out)
  );

  kwsl_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (core_out.count),
    .push_first  (core_out.first),
    .push_second (core_out.second),
    .pop         (pop),
    .head        (head),
    .count       (count)
  );

  // Result side
  assign token_valid  = count != '0;
  assign pop          = token_valid && !token_stall;
  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign too_long     = head.too_long;
  assign last         = head.last;

  // Checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    core_out.halted |=> core_out.halted)
    else $error("halt released without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    core_out.halted |-> core_out.count == 2'd0)
    else $error("token produced while halted");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> src_valid && count > CNT_W'(FIFO_DEPTH - 2))
    else $error("input stalled without a full queue");

endmodule

// ----- design/kwsl_core.sv -----
// Lexer state and per-byte token logic.
`timescale 1ns / 1ps

module kwsl_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [7:0]          cur_byte,
  output kwsl_pkg::core_out_t core_out
);
  import kwsl_pkg::*;

  lexer_mode_t             mode, mode_next;
  logic                    quote_kind, quote_kind_next;
  logic [LEN_W-1:0]        text_length, text_length_next;
  logic [OFFSET_WIDTH-1:0] start_offset, start_offset_next;
  logic [OFFSET_WIDTH-1:0] byte_offset, byte_offset_next;
  logic [2:0]              keyword_hits, keyword_hits_next;
  logic                    halted, halted_next;

  // Character classes and derived values
  logic                    c_space, c_alpha, c_alnum, c_quote, c_colon, c_nul;
  logic                    str_close;
  logic [LEN_W-1:0]        len_bumped, len_sat;
  logic                    len_over;
  logic                    idle_emits;
  tok_t                    idle_tok, ident_tok, str_tok;

  assign c_space    = is_space(cur_byte);
  assign c_alpha    = is_alpha(cur_byte);
  assign c_alnum    = is_alnum(cur_byte);
  assign c_quote    = (cur_byte == CH_DQUOTE) || (cur_byte == CH_SQUOTE);
  assign c_colon    = (cur_byte == CH_COLON);
  assign c_nul      = (cur_byte == CH_NUL);
  assign str_close  = cur_byte == (quote_kind ? CH_SQUOTE : CH_DQUOTE);
  assign len_bumped = (text_length <= MAX_LEN) ? text_length + 1'b1 : text_length;
  assign len_over   = text_length > MAX_LEN;
  assign len_sat    = len_over ? MAX_LEN : text_length;
  assign idle_emits = !c_space && !c_alpha && !c_quote;

  // Token from the between-tokens path: colon, end of input or error
  always_comb begin
    idle_tok          = '0;
    idle_tok.start    = START_W'(byte_offset);
    idle_tok.too_long = 1'b0;
    idle_tok.last     = 1'b1;
    if (c_colon) begin
      idle_tok.kind   = KIND_COLON;
      idle_tok.length = LEN_W'(1);
    end else if (c_nul) begin
      idle_tok.kind   = KIND_EOI;
      idle_tok.length = '0;
    end else begin
      idle_tok.kind   = KIND_ERROR;
      idle_tok.length = LEN_W'(1);
    end
  end

  // Identifier that ends at this byte
  always_comb begin
    ident_tok          = '0;
    ident_tok.kind     = KIND_SYMBOL;
    ident_tok.start    = START_W'(start_offset);
    ident_tok.length   = len_sat;
    ident_tok.too_long = len_over;
    ident_tok.last     = !idle_emits;
    for (int i = 0; i < 3; i++) begin
      if (keyword_hits[i] && text_length == kw_len(2'(i))) begin
        ident_tok.kind = token_kind_t'(3'(i));
      end
    end
  end

  // String closed by quote or broken by NUL
  always_comb begin
    str_tok          = '0;
    str_tok.kind     = c_nul ? KIND_ERROR : KIND_STRING;
    str_tok.start    = START_W'(start_offset);
    str_tok.length   = len_sat;
    str_tok.too_long = len_over;
    str_tok.last     = 1'b1;
  end

  // Next state
  always_comb begin
    mode_next         = mode;
    quote_kind_next   = quote_kind;
    text_length_next  = text_length;
    start_offset_next = start_offset;
    byte_offset_next  = byte_offset;
    keyword_hits_next = keyword_hits;
    halted_next       = halted;
    if (go && !halted) begin
      byte_offset_next = byte_offset + 1'b1;
      if (mode == MODE_STR) begin
        if (str_close) begin
          mode_next = MODE_IDLE;
        end else if (c_nul) begin
          mode_next   = MODE_IDLE;
          halted_next = 1'b1;
        end else begin
          text_length_next = len_bumped;
        end
      end else if (mode == MODE_IDENT && c_alnum) begin
        keyword_hits_next = kw_match(keyword_hits, text_length, cur_byte);
        text_length_next  = len_bumped;
      end else begin
        // Between tokens, or the byte that ends an identifier
        mode_next = MODE_IDLE;
        if (c_alpha) begin
          mode_next         = MODE_IDENT;
          start_offset_next = byte_offset;
          text_length_next  = LEN_W'(1);
          keyword_hits_next = kw_match(3'b111, '0, cur_byte);
        end else if (c_quote) begin
          mode_next         = MODE_STR;
          quote_kind_next   = (cur_byte == CH_SQUOTE);
          start_offset_next = byte_offset + 1'b1;
          text_length_next  = '0;
        end else if (!c_space && !c_colon && !c_nul) begin
          halted_next = 1'b1;
        end
      end
    end
  end

  // Outputs: tokens for this byte
  always_comb begin
    core_out        = '0;
    core_out.halted = halted;
    core_out.first  = idle_tok;
    core_out.second = idle_tok;
    if (go && !halted) begin
      unique case (mode)
        MODE_IDENT: begin
          if (!c_alnum) begin
            core_out.first = ident_tok;
            core_out.count = idle_emits ? 2'd2 : 2'd1;
          end
        end
        MODE_STR: begin
          core_out.first = str_tok;
          core_out.count = (str_close || c_nul) ? 2'd1 : 2'd0;
        end
        default: begin
          core_out.count = idle_emits ? 2'd1 : 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      quote_kind   <= 1'b0;
      text_length  <= '0;
      start_offset <= '0;
      byte_offset  <= '0;
      keyword_hits <= '0;
      halted       <= 1'b0;
    end else begin
      mode         <= mode_next;
      quote_kind   <= quote_kind_next;
      text_length  <= text_length_next;
      start_offset <= start_offset_next;
      byte_offset  <= byte_offset_next;
      keyword_hits <= keyword_hits_next;
      halted       <= halted_next;
    end
  end

endmodule

// ----- design/kwsl_fifo.sv -----
// Result queue: takes up to two tokens per cycle, gives one per cycle when popped.
`timescale 1ns / 1ps

module kwsl_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 push_count,
  input  kwsl_pkg::tok_t             push_first,
  input  kwsl_pkg::tok_t             push_second,
  input  logic                       pop,
  output kwsl_pkg::tok_t             head,
  output logic [kwsl_pkg::CNT_W-1:0] count
);
  import kwsl_pkg::*;

  tok_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] rd_ptr, wr_ptr;
  logic [FIFO_AW-1:0] wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + 1'b1;
  assign head         = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_plus1] <= push_second;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

endmodule
